// ===== sv/pbrb_pkg.sv =====
// Package for the particle boundary region binner: region codes, side codes and the region map.
`timescale 1ns / 1ps

package pbrb_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;

    localparam int REGION_WIDTH  = 5;
    localparam int COUNT_WIDTH   = 17;
    localparam int NUMBER_WIDTH  = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_REGIONS   = 26;

    // Counters stop at this value.
    localparam logic [COUNT_WIDTH-1:0] SLOT_LIMIT = 17'h10000;

    localparam logic [REGION_WIDTH-1:0] FACE_X_BASE   = 5'd0;
    localparam logic [REGION_WIDTH-1:0] FACE_Y_BASE   = 5'd2;
    localparam logic [REGION_WIDTH-1:0] FACE_Z_BASE   = 5'd4;
    localparam logic [REGION_WIDTH-1:0] EDGE_XY_BASE  = 5'd6;
    localparam logic [REGION_WIDTH-1:0] EDGE_XZ_BASE  = 5'd10;
    localparam logic [REGION_WIDTH-1:0] EDGE_YZ_BASE  = 5'd14;
    localparam logic [REGION_WIDTH-1:0] VERTEX_BASE   = 5'd18;
    localparam logic [REGION_WIDTH-1:0] LAST_REGION   = 5'd25;
    localparam logic [REGION_WIDTH-1:0] CODE_INSIDE   = 5'd26;
    localparam logic [REGION_WIDTH-1:0] CODE_DEAD     = 5'd27;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Z_HIGH = 3'd5;

    localparam logic       KIND_PARTICLE = 1'b0;
    localparam logic       KIND_REPORT   = 1'b1;

    typedef enum logic [1:0] {
        SIDE_IN   = 2'd0,
        SIDE_LOW  = 2'd1,
        SIDE_HIGH = 2'd2
    } side_t;

    typedef struct packed {
        side_t sx;
        side_t sy;
        side_t sz;
    } sides_t;

    // Maps the three per-axis sides to a region code.
    function automatic logic [REGION_WIDTH-1:0] region_of(sides_t s);
        logic                    ox;
        logic                    oy;
        logic                    oz;
        logic                    hx;
        logic                    hy;
        logic                    hz;
        logic [1:0]              n;
        logic [REGION_WIDTH-1:0] code;
        begin
            ox = (s.sx != SIDE_IN);
            oy = (s.sy != SIDE_IN);
            oz = (s.sz != SIDE_IN);
            hx = (s.sx == SIDE_HIGH);
            hy = (s.sy == SIDE_HIGH);
            hz = (s.sz == SIDE_HIGH);
            n  = {1'b0, ox} + {1'b0, oy} + {1'b0, oz};
            case (n)
                2'd0: code = CODE_INSIDE;
                2'd1:
                begin
                    if (ox)
                        code = FACE_X_BASE + {4'b0, hx};
                    else if (oy)
                        code = FACE_Y_BASE + {4'b0, hy};
                    else
                        code = FACE_Z_BASE + {4'b0, hz};
                end
                2'd2:
                begin
                    if (!oz)
                        code = EDGE_XY_BASE + {3'b0, hx, hy};
                    else if (!oy)
                        code = EDGE_XZ_BASE + {3'b0, hx, hz};
                    else
                        code = EDGE_YZ_BASE + {3'b0, hy, hz};
                end
                default: code = VERTEX_BASE + {2'b0, hx, hy, hz};
            endcase
            return code;
        end
    endfunction

endpackage

// ===== sv/pbrb_classify.sv =====
// Per-axis bound comparison and region lookup for one particle.
`timescale 1ns / 1ps

module pbrb_classify #(
    parameter int COORD_WIDTH = pbrb_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic signed [COORD_WIDTH-1:0]        pos_x,
    input  logic signed [COORD_WIDTH-1:0]        pos_y,
    input  logic signed [COORD_WIDTH-1:0]        pos_z,
    input  logic signed [COORD_WIDTH-1:0]        x_low,
    input  logic signed [COORD_WIDTH-1:0]        x_high,
    input  logic signed [COORD_WIDTH-1:0]        y_low,
    input  logic signed [COORD_WIDTH-1:0]        y_high,
    input  logic signed [COORD_WIDTH-1:0]        z_low,
    input  logic signed [COORD_WIDTH-1:0]        z_high,
    input  logic                                 dead,
    output logic [pbrb_pkg::REGION_WIDTH-1:0]    region
);
    import pbrb_pkg::*;

    sides_t sides;

    // The below-low test wins when the bounds cross.
    always_comb
    begin
        sides.sx = (pos_x < x_low) ? SIDE_LOW : ((pos_x > x_high) ? SIDE_HIGH : SIDE_IN);
        sides.sy = (pos_y < y_low) ? SIDE_LOW : ((pos_y > y_high) ? SIDE_HIGH : SIDE_IN);
        sides.sz = (pos_z < z_low) ? SIDE_LOW : ((pos_z > z_high) ? SIDE_HIGH : SIDE_IN);
    end

    assign region = dead ? CODE_DEAD : region_of(sides);

endmodule

// ===== sv/particle_boundary_region_binner.sv =====
// Top level of the particle boundary region binner.
`timescale 1ns / 1ps

// Bins a stream of particles into the 26 exit regions of a 3-D patch. One particle
// transaction is taken per clock while in_stall is low; its classification is loaded
// from the input register into the output register, which each hold one transaction,
// so the stream runs at one particle per cycle whenever the downstream side does not
// stall and no count reports are being sent. The slot of a particle in one of the 26
// regions is the count of earlier particles of that region in the batch, read from and
// incremented in a bank of 26 counters in the same cycle. After the particle flagged
// batch_last, the block sends 26 count reports, one per cycle in region order while
// the output does not stall, through the same output register; the particle path holds
// meanwhile (one further particle may wait in the input register). The particle number
// clears when the batch_last particle leaves the input register, and the counters clear
// with the last report. Bound registers reset to zero; the user must write them through
// the cfg port only while the block is idle, and the block itself does not enforce this.
module particle_boundary_region_binner #(
    parameter int COORD_WIDTH = pbrb_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [pbrb_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]                cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COORD_WIDTH-1:0]         pos_x,
    input  logic signed [COORD_WIDTH-1:0]         pos_y,
    input  logic signed [COORD_WIDTH-1:0]         pos_z,
    input  logic                                  dead_flag,
    input  logic                                  batch_last,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  report_kind,
    output logic [pbrb_pkg::REGION_WIDTH-1:0]     region_code,
    output logic [pbrb_pkg::COUNT_WIDTH-1:0]      slot_or_count,
    output logic [pbrb_pkg::NUMBER_WIDTH-1:0]     particle_number,
    output logic                                  result_last
);
    import pbrb_pkg::*;

    logic signed [COORD_WIDTH-1:0] x_low_reg;
    logic signed [COORD_WIDTH-1:0] x_high_reg;
    logic signed [COORD_WIDTH-1:0] y_low_reg;
    logic signed [COORD_WIDTH-1:0] y_high_reg;
    logic signed [COORD_WIDTH-1:0] z_low_reg;
    logic signed [COORD_WIDTH-1:0] z_high_reg;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic signed [COORD_WIDTH-1:0] pos_x_reg;
    logic signed [COORD_WIDTH-1:0] pos_y_reg;
    logic signed [COORD_WIDTH-1:0] pos_z_reg;
    logic                          dead_reg;
    logic                          last_reg;

    logic [COUNT_WIDTH-1:0]        count_reg [NUM_REGIONS];
    logic [NUMBER_WIDTH-1:0]       position_reg;
    logic [NUMBER_WIDTH-1:0]       position_next;
    logic                          rpt_active_reg;
    logic                          rpt_active_next;
    logic [REGION_WIDTH-1:0]       rpt_idx_reg;
    logic [REGION_WIDTH-1:0]       rpt_idx_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          kind_reg;
    logic [REGION_WIDTH-1:0]       code_reg;
    logic [COUNT_WIDTH-1:0]        count_out_reg;
    logic [NUMBER_WIDTH-1:0]       number_reg;
    logic                          last_out_reg;

    logic                          in_take;
    logic                          out_free;
    logic                          advance;
    logic                          rpt_load;
    logic                          rpt_done;
    logic [REGION_WIDTH-1:0]       region;
    logic                          is_region;
    logic [COUNT_WIDTH-1:0]        slot;
    logic                          bump;

    // Bound registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= '0;
            x_high_reg <= '0;
            y_low_reg  <= '0;
            y_high_reg <= '0;
            z_low_reg  <= '0;
            z_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_X_LOW:  x_low_reg  <= cfg_data;
                REG_X_HIGH: x_high_reg <= cfg_data;
                REG_Y_LOW:  y_low_reg  <= cfg_data;
                REG_Y_HIGH: y_high_reg <= cfg_data;
                REG_Z_LOW:  z_low_reg  <= cfg_data;
                REG_Z_HIGH: z_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && !rpt_active_reg && out_free;
    assign rpt_load = rpt_active_reg && out_free;
    assign rpt_done = rpt_load && (rpt_idx_reg == LAST_REGION);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    pbrb_classify #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_classify (
        .pos_x  (pos_x_reg),
        .pos_y  (pos_y_reg),
        .pos_z  (pos_z_reg),
        .x_low  (x_low_reg),
        .x_high (x_high_reg),
        .y_low  (y_low_reg),
        .y_high (y_high_reg),
        .z_low  (z_low_reg),
        .z_high (z_high_reg),
        .dead   (dead_reg),
        .region (region)
    );

    assign is_region = (region <= LAST_REGION);
    assign slot      = is_region ? count_reg[region] : '0;
    assign bump      = advance && is_region && (slot < SLOT_LIMIT);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        position_next = position_reg;
        if (advance)
            position_next = last_reg ? '0 : position_reg + 1'b1;

        rpt_active_next = rpt_active_reg;
        rpt_idx_next    = rpt_idx_reg;
        if (advance && last_reg)
        begin
            rpt_active_next = 1'b1;
            rpt_idx_next    = '0;
        end
        else if (rpt_load)
        begin
            rpt_active_next = !rpt_done;
            rpt_idx_next    = rpt_idx_reg + 1'b1;
        end

        if (advance || rpt_load)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            position_reg   <= '0;
            rpt_active_reg <= 1'b0;
            rpt_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            position_reg   <= position_next;
            rpt_active_reg <= rpt_active_next;
            rpt_idx_reg    <= rpt_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Region counters clear together with the final count report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGIONS; i++)
                count_reg[i] <= '0;
        end
        else if (rpt_done)
        begin
            for (int i = 0; i < NUM_REGIONS; i++)
                count_reg[i] <= '0;
        end
        else if (bump)
        begin
            count_reg[region] <= slot + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            pos_z_reg <= pos_z;
            dead_reg  <= dead_flag;
            last_reg  <= batch_last;
        end

        if (advance)
        begin
            kind_reg      <= KIND_PARTICLE;
            code_reg      <= region;
            count_out_reg <= slot;
            number_reg    <= position_reg;
            last_out_reg  <= 1'b0;
        end
        else if (rpt_load)
        begin
            kind_reg      <= KIND_REPORT;
            code_reg      <= rpt_idx_reg;
            count_out_reg <= count_reg[rpt_idx_reg];
            number_reg    <= '0;
            last_out_reg  <= (rpt_idx_reg == LAST_REGION);
        end
    end

    assign out_valid       = out_valid_reg;
    assign report_kind     = kind_reg;
    assign region_code     = code_reg;
    assign slot_or_count   = count_out_reg;
    assign particle_number = number_reg;
    assign result_last     = last_out_reg;

endmodule

// ===== test/pbrb_region_checker.sv =====
// Checker for the particle boundary region binner: predicts every result and compares it.
`timescale 1ns / 1ps

module pbrb_region_checker
    import pbrb_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [CFG_IDX_WIDTH-1:0]           cfg_index,
    input  logic [COORD_WIDTH_DEFAULT-1:0]     cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [COORD_WIDTH_DEFAULT-1:0] pos_x,
    input  logic signed [COORD_WIDTH_DEFAULT-1:0] pos_y,
    input  logic signed [COORD_WIDTH_DEFAULT-1:0] pos_z,
    input  logic                               dead_flag,
    input  logic                               batch_last,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               report_kind,
    input  logic [REGION_WIDTH-1:0]            region_code,
    input  logic [COUNT_WIDTH-1:0]             slot_or_count,
    input  logic [NUMBER_WIDTH-1:0]            particle_number,
    input  logic                               result_last,
    output int                                 mismatches,
    output int                                 outstanding
);

    localparam int CW = COORD_WIDTH_DEFAULT;

    typedef struct packed {
        logic                    kind;
        logic [REGION_WIDTH-1:0] region;
        logic [COUNT_WIDTH-1:0]  tally;
        logic [NUMBER_WIDTH-1:0] number;
        logic                    tail;
    } binned_result_t;

    binned_result_t          binned_results[$];
    binned_result_t          oldest;
    logic signed [CW-1:0]    x_low, x_high, y_low, y_high, z_low, z_high;
    logic [COUNT_WIDTH-1:0]  region_tally [NUM_REGIONS];
    logic [NUMBER_WIDTH-1:0] batch_position;
    int                      fail_total;

    assign mismatches = fail_total;

    function automatic side_t classify_axis(logic signed [CW-1:0] v,
                                            logic signed [CW-1:0] lo,
                                            logic signed [CW-1:0] hi);
        if (v < lo)
            return SIDE_LOW;
        if (v > hi)
            return SIDE_HIGH;
        return SIDE_IN;
    endfunction

    function automatic logic [REGION_WIDTH-1:0] exit_region(side_t sx, side_t sy, side_t sz);
        logic hx;
        logic hy;
        logic hz;
        int   outs;
        hx = (sx == SIDE_HIGH);
        hy = (sy == SIDE_HIGH);
        hz = (sz == SIDE_HIGH);
        outs = int'(sx != SIDE_IN) + int'(sy != SIDE_IN) + int'(sz != SIDE_IN);
        if (outs == 0)
            return CODE_INSIDE;
        if (outs == 3)
            return VERTEX_BASE + {2'b0, hx, hy, hz};
        if (outs == 1)
        begin
            if (sx != SIDE_IN)
                return FACE_X_BASE + {4'b0, hx};
            if (sy != SIDE_IN)
                return FACE_Y_BASE + {4'b0, hy};
            return FACE_Z_BASE + {4'b0, hz};
        end
        // Two axes out: the edge group is chosen by the axis that stays inside and named by the two axes out.
        if (sz == SIDE_IN)
            return EDGE_XY_BASE + {3'b0, hx, hy};
        if (sy == SIDE_IN)
            return EDGE_XZ_BASE + {3'b0, hx, hz};
        return EDGE_YZ_BASE + {3'b0, hy, hz};
    endfunction

    task automatic record_particle();
        binned_result_t          item;
        logic [REGION_WIDTH-1:0] code;
        logic [COUNT_WIDTH-1:0]  slot;
        slot = '0;
        if (dead_flag)
            code = CODE_DEAD;
        else
        begin
            code = exit_region(classify_axis(pos_x, x_low, x_high),
                               classify_axis(pos_y, y_low, y_high),
                               classify_axis(pos_z, z_low, z_high));
            if (code < NUM_REGIONS)
            begin
                slot = region_tally[code];
                if (slot < SLOT_LIMIT)
                    region_tally[code] = slot + 1'b1;
            end
        end
        item = '{KIND_PARTICLE, code, slot, batch_position, 1'b0};
        binned_results.push_back(item);
        batch_position = batch_position + 1'b1;
        if (batch_last)
        begin
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                item = '{KIND_REPORT, REGION_WIDTH'(r), region_tally[r], '0,
                         r == NUM_REGIONS - 1};
                binned_results.push_back(item);
                region_tally[r] = '0;
            end
            batch_position = '0;
        end
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            fail_total++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binned_results.delete();
            x_low  <= '0;
            x_high <= '0;
            y_low  <= '0;
            y_high <= '0;
            z_low  <= '0;
            z_high <= '0;
            for (int r = 0; r < NUM_REGIONS; r++)
                region_tally[r] = '0;
            batch_position = '0;
            outstanding <= 0;
        end
        else
        begin
            // The input transaction is predicted first; its results cannot leave this edge.
            if (in_valid && !in_stall)
                record_particle();
            if (out_valid && !out_stall)
            begin
                if (binned_results.size() == 0)
                begin
                    fail_total++;
                    $error("region_code: expected no result, actual %0d", region_code);
                end
                else
                begin
                    oldest = binned_results.pop_front();
                    compare_field("report_kind", oldest.kind, report_kind);
                    compare_field("region_code", oldest.region, region_code);
                    compare_field("slot_or_count", oldest.tally, slot_or_count);
                    compare_field("particle_number", oldest.number, particle_number);
                    compare_field("result_last", oldest.tail, result_last);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_X_LOW:  x_low  <= cfg_data;
                    REG_X_HIGH: x_high <= cfg_data;
                    REG_Y_LOW:  y_low  <= cfg_data;
                    REG_Y_HIGH: y_high <= cfg_data;
                    REG_Z_LOW:  z_low  <= cfg_data;
                    REG_Z_HIGH: z_high <= cfg_data;
                    default: ;
                endcase
            end
            outstanding <= binned_results.size();
        end
    end

    initial
    begin
        fail_total = 0;
    end

endmodule

// ===== test/particle_boundary_region_binner_tb.sv =====
// Testbench top for the particle boundary region binner: stimulus, reset and verdict.
`timescale 1ns / 1ps

module particle_boundary_region_binner_tb;

    import pbrb_pkg::*;

    localparam int CW = COORD_WIDTH_DEFAULT;
    localparam logic signed [CW-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] COORD_MAX = 32'sh7fff_ffff;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]   cfg_index = '0;
    logic [CW-1:0]              cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [CW-1:0]       pos_x = '0;
    logic signed [CW-1:0]       pos_y = '0;
    logic signed [CW-1:0]       pos_z = '0;
    logic                       dead_flag = 1'b0;
    logic                       batch_last = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       report_kind;
    logic [REGION_WIDTH-1:0]    region_code;
    logic [COUNT_WIDTH-1:0]     slot_or_count;
    logic [NUMBER_WIDTH-1:0]    particle_number;
    logic                       result_last;
    int                         mismatches;
    int                         outstanding;

    // When set, neither side idles.
    logic                       steady = 1'b0;
    logic signed [CW-1:0]       lo_b [3];
    logic signed [CW-1:0]       hi_b [3];

    particle_boundary_region_binner DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .dead_flag       (dead_flag),
        .batch_last      (batch_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .report_kind     (report_kind),
        .region_code     (region_code),
        .slot_or_count   (slot_or_count),
        .particle_number (particle_number),
        .result_last     (result_last)
    );

    pbrb_region_checker region_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .dead_flag       (dead_flag),
        .batch_last      (batch_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .report_kind     (report_kind),
        .region_code     (region_code),
        .slot_or_count   (slot_or_count),
        .particle_number (particle_number),
        .result_last     (result_last),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 35);
    end

    // A coordinate on the requested side of one axis, one step past the bound when outside.
    function automatic logic signed [CW-1:0] coord_on(side_t want, logic signed [CW-1:0] lo,
                                                      logic signed [CW-1:0] hi);
        logic signed [CW:0] mid;
        mid = ($signed({lo[CW-1], lo}) + $signed({hi[CW-1], hi})) >>> 1;
        case (want)
            SIDE_LOW:  return lo - 1;
            SIDE_HIGH: return hi + 1;
            default:   return mid[CW-1:0];
        endcase
    endfunction

    // Mostly values at or near the bounds, with fully random ones mixed in.
    function automatic logic signed [CW-1:0] coord_near(logic signed [CW-1:0] lo,
                                                        logic signed [CW-1:0] hi);
        logic signed [CW-1:0] step;
        step = $signed($urandom_range(1000, 1));
        case ($urandom_range(5))
            0:       return lo - step;
            1:       return lo;
            2:       return hi;
            3:       return hi + step;
            4:       return coord_on(SIDE_IN, lo, hi);
            default: return $urandom();
        endcase
    endfunction

    task automatic pick_axis_bounds(output logic signed [CW-1:0] lo,
                                    output logic signed [CW-1:0] hi);
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        a = $urandom();
        b = $urandom();
        case ($urandom_range(3))
            0:
            begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            1:
            begin
                // Inverted window: the low test wins on this axis.
                lo = (a < b) ? b : a;
                hi = (a < b) ? a : b;
            end
            2:
            begin
                lo = a;
                hi = a;
            end
            default:
            begin
                lo = -$signed($urandom_range(32'h0010_0000, 1));
                hi = $signed($urandom_range(32'h0010_0000, 1));
            end
        endcase
    endtask

    task automatic reg_write(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CW-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_bounds(input logic signed [CW-1:0] xl, xh, yl, yh, zl, zh);
        lo_b[0] = xl;
        hi_b[0] = xh;
        lo_b[1] = yl;
        hi_b[1] = yh;
        lo_b[2] = zl;
        hi_b[2] = zh;
        reg_write(REG_X_LOW, xl);
        reg_write(REG_X_HIGH, xh);
        reg_write(REG_Y_LOW, yl);
        reg_write(REG_Y_HIGH, yh);
        reg_write(REG_Z_LOW, zl);
        reg_write(REG_Z_HIGH, zh);
        cfg_write <= 1'b0;
    endtask

    task automatic send_particle(input logic signed [CW-1:0] x, y, z,
                                 input logic dead, input logic last);
        while (!steady && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        dead_flag  <= dead;
        batch_last <= last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_sides(input side_t sx, sy, sz, input logic dead, input logic last);
        send_particle(coord_on(sx, lo_b[0], hi_b[0]), coord_on(sy, lo_b[1], hi_b[1]),
                      coord_on(sz, lo_b[2], hi_b[2]), dead, last);
    endtask

    // Holds the input back until every predicted result has left the block.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic signed [CW-1:0] bl [3];
        logic signed [CW-1:0] bh [3];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_bounds(-32'sh0064_0000, 32'sh0064_0000, -32'sh00c8_0000, 32'sh00c8_0000,
                    -32'sh012c_0000, 32'sh012c_0000);
        send_sides(SIDE_IN, SIDE_IN, SIDE_IN, 1'b0, 1'b0);
        send_sides(SIDE_LOW, SIDE_IN, SIDE_IN, 1'b0, 1'b0);
        send_sides(SIDE_HIGH, SIDE_IN, SIDE_IN, 1'b0, 1'b0);
        send_sides(SIDE_IN, SIDE_LOW, SIDE_IN, 1'b0, 1'b0);
        send_sides(SIDE_IN, SIDE_HIGH, SIDE_IN, 1'b0, 1'b0);
        send_sides(SIDE_IN, SIDE_IN, SIDE_LOW, 1'b0, 1'b0);
        send_sides(SIDE_IN, SIDE_IN, SIDE_HIGH, 1'b0, 1'b0);
        send_sides(SIDE_HIGH, SIDE_LOW, SIDE_IN, 1'b0, 1'b0);
        send_sides(SIDE_LOW, SIDE_IN, SIDE_HIGH, 1'b0, 1'b0);
        send_sides(SIDE_IN, SIDE_HIGH, SIDE_LOW, 1'b0, 1'b0);
        send_sides(SIDE_LOW, SIDE_LOW, SIDE_LOW, 1'b0, 1'b0);
        send_sides(SIDE_HIGH, SIDE_HIGH, SIDE_HIGH, 1'b0, 1'b0);
        // Coordinates equal to a bound are inside, since the tests are strict.
        send_particle(lo_b[0], lo_b[1], lo_b[2], 1'b0, 1'b0);
        send_particle(hi_b[0], hi_b[1], hi_b[2], 1'b0, 1'b0);
        send_particle(COORD_MIN, COORD_MAX, 0, 1'b0, 1'b0);
        send_sides(SIDE_HIGH, SIDE_LOW, SIDE_HIGH, 1'b1, 1'b0);
        send_sides(SIDE_LOW, SIDE_IN, SIDE_IN, 1'b0, 1'b0);
        // A dead particle may close the batch.
        send_sides(SIDE_LOW, SIDE_LOW, SIDE_IN, 1'b1, 1'b1);
        drain();

        load_bounds(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_particle(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        send_particle(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
        drain();

        // Fully inverted window: only the largest value escapes the low test.
        load_bounds(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_particle(0, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_particle(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_particle(COORD_MIN, 0, COORD_MAX, 1'b0, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            for (int a = 0; a < 3; a++)
                pick_axis_bounds(bl[a], bh[a]);
            load_bounds(bl[0], bh[0], bl[1], bh[1], bl[2], bh[2]);
            steady <= (ph == 2);
            for (int k = 0; k < 73; k++)
                send_particle(coord_near(lo_b[0], hi_b[0]), coord_near(lo_b[1], hi_b[1]),
                              coord_near(lo_b[2], hi_b[2]), $urandom_range(9) == 0,
                              (ph == 5 && k == 72) || $urandom_range(15) == 0);
            drain();
        end
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("[particle_boundary_region_binner] OK");
        else
            $display("[particle_boundary_region_binner] ERROR");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("[particle_boundary_region_binner] ERROR");
        $finish;
    end

endmodule

// ===== particle_boundary_region_binner.f =====
sv/pbrb_pkg.sv
sv/pbrb_classify.sv
sv/particle_boundary_region_binner.sv
test/pbrb_region_checker.sv
test/particle_boundary_region_binner_tb.sv
